// ===== hw/rtl/section_address_translator_unit_assert.svh =====
// Assertion macros for the section address translator.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef SECTION_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`define SECTION_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define SAT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAT_ASSERT(lbl, clk, rstn, prop, msg)
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/sat_pkg.sv =====
// Shared types and constants of the section address translator.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package sat_pkg;

	// Default depth of the section table.
	localparam int unsigned MAX_SECTIONS_DEF = 32;

	// Configuration port geometry: 64-bit registers at eight-byte strides.
	localparam int unsigned APB_AW    = 5;
	localparam int unsigned APB_DW    = 64;
	localparam int unsigned REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_IMAGE_BASE    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FILE_SIZE     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_IMAGE_SIZE    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SECTION_COUNT = 2'd3;

	// Command codes of an input item.
	typedef enum logic [2:0] {
		CMD_WRITE    = 3'd0,
		CMD_V2O      = 3'd1,
		CMD_O2V      = 3'd2,
		CMD_SECTION  = 3'd3,
		CMD_CONTAINS = 3'd4
	} cmd_e_t;

	// One table entry, with the section ends and the raw-minus-virtual
	// distance worked out when the entry is written.
	typedef struct packed {
		logic [31:0] vstart;
		logic [32:0] vend;    // vstart + virtual length
		logic [32:0] send;    // vstart + larger of the two lengths
		logic [31:0] rstart;
		logic [32:0] rend;    // rstart + raw length
		logic [32:0] rdelta;  // rstart - vstart, modulo 2^33
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // input transfer taken this cycle
		logic rd_en;       // read one table entry
		logic set_simple;  // result needs no table search
		logic set_hit;     // take the matching entry's result
		logic set_fail;    // search ended without a match
		logic out_load;    // move the result into the output register
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_req;   // the held query searches the table
		logic hit;        // the entry at the end of the pipeline matches
		logic pipe_busy;  // entries are still in flight
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sat_regs.sv =====
// Configuration registers of the section address translator behind an APB-style port.
// Depends on sat_pkg for the register map.
`default_nettype none

module sat_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sat_pkg::APB_AW-1:0]   paddr,
	input  wire logic [sat_pkg::APB_DW-1:0]   pwdata,
	output logic      [sat_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	output logic      [63:0]                  image_base,
	output logic      [31:0]                  file_len,
	output logic      [31:0]                  image_size,
	output logic      [5:0]                   section_count
);

	logic [sat_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;
	logic [63:0]                   image_base_q;
	logic [31:0]                   file_len_q;
	logic [31:0]                   image_size_q;
	logic [5:0]                    section_count_q;

	// The port never inserts wait states.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q    <= '0;
			file_len_q      <= '0;
			image_size_q    <= '0;
			section_count_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				sat_pkg::REG_IMAGE_BASE:    image_base_q    <= pwdata;
				sat_pkg::REG_FILE_SIZE:     file_len_q      <= pwdata[31:0];
				sat_pkg::REG_IMAGE_SIZE:    image_size_q    <= pwdata[31:0];
				sat_pkg::REG_SECTION_COUNT: section_count_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			sat_pkg::REG_IMAGE_BASE:    prdata = image_base_q;
			sat_pkg::REG_FILE_SIZE:     prdata = {32'd0, file_len_q};
			sat_pkg::REG_IMAGE_SIZE:    prdata = {32'd0, image_size_q};
			sat_pkg::REG_SECTION_COUNT: prdata = {58'd0, section_count_q};
			default:                    prdata = '0;
		endcase
	end

	assign image_base    = image_base_q;
	assign file_len      = file_len_q;
	assign image_size    = image_size_q;
	assign section_count = section_count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sat_dpath.sv =====
// Datapath of the section address translator: section table memory, search pipeline
// and result registers. Depends on sat_pkg; driven by sat_ctrl.
`default_nettype none

module sat_dpath #(
	parameter  int unsigned MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
	localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [2:0]           command,
	input  wire logic [63:0]          address,
	input  wire logic [4:0]           entry_index,
	input  wire logic [31:0]          virt_start,
	input  wire logic [31:0]          virt_length,
	input  wire logic [31:0]          raw_start,
	input  wire logic [31:0]          raw_length,
	input  wire logic [63:0]          image_base,
	input  wire logic [31:0]          file_len,
	input  wire logic [31:0]          image_size,
	input  wire sat_pkg::ctl_cmd_t    cmd,
	input  wire logic [IDX_W-1:0]     rd_idx,
	output sat_pkg::ctl_sts_t         sts,
	output logic                      found,
	output logic [63:0]               result_value
);

	sat_pkg::entry_t  mem [MAX_SECTIONS];
	sat_pkg::entry_t  wr_entry;
	sat_pkg::entry_t  ent_s1;
	sat_pkg::cmd_e_t  cmd_q;
	logic [63:0]      addr_q;
	logic [63:0]      rva_q;
	logic             below_q;
	logic             wr_ok_q;
	logic [64:0]      diff;
	logic             wr_ok;
	logic [31:0]      span;
	logic             vld_s1, vld_s2;
	logic [IDX_W-1:0] idx_s1, idx_s2;
	logic             covered;
	logic [32:0]      val;
	logic             cover_s2;
	logic [32:0]      val_s2;
	logic             hit;
	logic [63:0]      hit_val;
	logic             simple_found;
	logic             res_found_q;
	logic [63:0]      res_val_q;
	logic             found_q;
	logic [63:0]      result_q;

	// Address relative to the image base; the borrow flags an address below it.
	assign diff  = {1'b0, address} - {1'b0, image_base};
	assign wr_ok = (command == sat_pkg::CMD_WRITE) && (int'(entry_index) < MAX_SECTIONS);

	// Entry as stored, with its ends precomputed.
	always_comb begin
		span            = (virt_length > raw_length) ? virt_length : raw_length;
		wr_entry.vstart = virt_start;
		wr_entry.vend   = {1'b0, virt_start} + {1'b0, virt_length};
		wr_entry.send   = {1'b0, virt_start} + {1'b0, span};
		wr_entry.rstart = raw_start;
		wr_entry.rend   = {1'b0, raw_start} + {1'b0, raw_length};
		wr_entry.rdelta = {1'b0, raw_start} - {1'b0, virt_start};
	end

	// Query capture at the input transfer.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cmd_q   <= sat_pkg::cmd_e_t'(command);
			addr_q  <= address;
			rva_q   <= diff[63:0];
			below_q <= diff[64];
			wr_ok_q <= wr_ok;
		end
	end

	// Section table: written at the input transfer, read with a registered port.
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_ok) begin
			mem[IDX_W'(entry_index)] <= wr_entry;
		end
		if (cmd.rd_en) begin
			ent_s1 <= mem[rd_idx];
		end
	end

	// Valid tags of the search pipeline, flushed by each new query.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (cmd.accept) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			vld_s2 <= vld_s1;
		end
	end

	// Coverage test and candidate value of the entry just read.
	always_comb begin
		covered = 1'b0;
		val     = '0;
		case (cmd_q)
			sat_pkg::CMD_V2O: begin
				covered = (rva_q >= 64'(ent_s1.vstart)) && (rva_q < 64'(ent_s1.send));
				val     = rva_q[32:0] + ent_s1.rdelta;
			end
			sat_pkg::CMD_O2V: begin
				covered = (addr_q >= 64'(ent_s1.rstart)) && (addr_q < 64'(ent_s1.rend));
				val     = addr_q[32:0] - ent_s1.rdelta;
			end
			sat_pkg::CMD_SECTION: begin
				covered = (rva_q >= 64'(ent_s1.vstart)) && (rva_q < 64'(ent_s1.vend));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		idx_s1   <= rd_idx;
		idx_s2   <= idx_s1;
		cover_s2 <= covered;
		val_s2   <= val;
	end

	// Final match decision; a mapped offset must lie inside the file.
	always_comb begin
		hit = vld_s2 && cover_s2 &&
			((cmd_q != sat_pkg::CMD_V2O) || (val_s2 < {1'b0, file_len}));
		case (cmd_q)
			sat_pkg::CMD_O2V:     hit_val = image_base + 64'(val_s2);
			sat_pkg::CMD_SECTION: hit_val = 64'(idx_s2);
			default:              hit_val = 64'(val_s2);
		endcase
	end

	// Outcome of the commands that need no search.
	always_comb begin
		case (cmd_q)
			sat_pkg::CMD_WRITE:    simple_found = wr_ok_q;
			sat_pkg::CMD_CONTAINS: simple_found = !below_q && (rva_q < 64'(image_size));
			default:               simple_found = 1'b0;
		endcase
	end

	assign sts.scan_req  = (cmd_q == sat_pkg::CMD_O2V) ||
		(((cmd_q == sat_pkg::CMD_V2O) || (cmd_q == sat_pkg::CMD_SECTION)) && !below_q);
	assign sts.hit       = hit;
	assign sts.pipe_busy = vld_s1 || vld_s2;

	// Pending result and output register.
	always_ff @(posedge clk) begin
		if (cmd.set_simple) begin
			res_found_q <= simple_found;
			res_val_q   <= '0;
		end else if (cmd.set_hit) begin
			res_found_q <= 1'b1;
			res_val_q   <= hit_val;
		end else if (cmd.set_fail) begin
			res_found_q <= 1'b0;
			res_val_q   <= '0;
		end
		if (cmd.out_load) begin
			found_q  <= res_found_q;
			result_q <= res_val_q;
		end
	end

	assign found        = found_q;
	assign result_value = result_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sat_ctrl.sv =====
// Controller of the section address translator: query sequencing, search counter
// and output handshake. Depends on sat_pkg and the assertion macro header.
`default_nettype none

`include "section_address_translator_unit_assert.svh"

module sat_ctrl #(
	parameter  int unsigned MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF,
	localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1,
	localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire logic [5:0]           section_count,
	input  wire sat_pkg::ctl_sts_t    sts,
	output sat_pkg::ctl_cmd_t         cmd,
	output logic [IDX_W-1:0]          rd_idx
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] live_cnt;
	logic             out_valid_q;
	logic             do_scan;

	// Number of entries searched, limited to the table depth.
	always_comb begin
		if (int'(section_count) > MAX_SECTIONS) begin
			live_cnt = CNT_W'(MAX_SECTIONS);
		end else begin
			live_cnt = CNT_W'(section_count);
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign do_scan  = sts.scan_req && (live_cnt != '0);
	assign rd_idx   = cnt_q[IDX_W-1:0];

	// Commands to the datapath.
	always_comb begin
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.rd_en      = (state_q == ST_SCAN) && (cnt_q < live_cnt) && !sts.hit;
		cmd.set_simple = (state_q == ST_PREP) && !do_scan;
		cmd.set_hit    = (state_q == ST_SCAN) && sts.hit;
		cmd.set_fail   = (state_q == ST_SCAN) && !sts.hit && (cnt_q == live_cnt) &&
			!sts.pipe_busy;
		cmd.out_load   = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	end

	// State, search counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= do_scan ? ST_SCAN : ST_FIN;
				end
				ST_SCAN: begin
					if (cmd.rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cmd.set_hit || cmd.set_fail) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// A result never overwrites a transfer still waiting at the output.
	`SAT_ASSERT(a_load_free, clk, arst_n, cmd.out_load |-> (!out_valid_q || !out_stall), "result loaded over a pending transfer")
	// Table reads stay inside the live section count.
	`SAT_ASSERT(a_rd_range, clk, arst_n, cmd.rd_en |-> (cnt_q < live_cnt), "table read beyond the section count")
	// Every accepted transfer is followed by the decode cycle.
	`SAT_ASSERT(a_accept_prep, clk, arst_n, cmd.accept |=> (state_q == ST_PREP), "accepted query not decoded")
	// The table is read only while searching.
	`SAT_ASSERT_ALWAYS(a_rd_scan, clk, (state_q != ST_SCAN) |-> !cmd.rd_en, "table read outside a search")

endmodule

`default_nettype wire

// ===== hw/rtl/section_address_translator_unit.sv =====
// Sequencing: each accepted transfer is decoded in the prep state. A write, contains or
// unknown command, or a query that needs no search, goes straight to the finish state;
// a table query first searches up to n entries, n being the live section count, one entry
// per cycle. One item at a time: a new transfer is taken only once the result is loaded.
// Reset clears the configuration registers and all control state; the section table
// is undefined until written and needs no clearing pass.
`default_nettype none

module section_address_translator_unit #(
	parameter int unsigned MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sat_pkg::APB_AW-1:0]   paddr,
	input  wire logic [sat_pkg::APB_DW-1:0]   pwdata,
	output logic      [sat_pkg::APB_DW-1:0]   prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [2:0]                   command,
	input  wire logic [63:0]                  address,
	input  wire logic [4:0]                   entry_index,
	input  wire logic [31:0]                  virt_start,
	input  wire logic [31:0]                  virt_length,
	input  wire logic [31:0]                  raw_start,
	input  wire logic [31:0]                  raw_length,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              found,
	output logic [63:0]                       result_value
);

	localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	logic [63:0]        image_base;
	logic [31:0]        file_len;
	logic [31:0]        image_size;
	logic [5:0]         section_count;
	sat_pkg::ctl_cmd_t  cmd;
	sat_pkg::ctl_sts_t  sts;
	logic [IDX_W-1:0]   rd_idx;

	// Configuration registers.
	sat_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.image_base    (image_base),
		.file_len      (file_len),
		.image_size    (image_size),
		.section_count (section_count)
	);

	// Sequencing and handshake control.
	sat_ctrl #(
		.MAX_SECTIONS (MAX_SECTIONS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.section_count (section_count),
		.sts           (sts),
		.cmd           (cmd),
		.rd_idx        (rd_idx)
	);

	// Table and search datapath.
	sat_dpath #(
		.MAX_SECTIONS (MAX_SECTIONS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (command),
		.address      (address),
		.entry_index  (entry_index),
		.virt_start   (virt_start),
		.virt_length  (virt_length),
		.raw_start    (raw_start),
		.raw_length   (raw_length),
		.image_base   (image_base),
		.file_len     (file_len),
		.image_size   (image_size),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.sts          (sts),
		.found        (found),
		.result_value (result_value)
	);

endmodule

`default_nettype wire
